// ----- design/longest_unique_symbol_run_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the longest unique symbol run block
// Clocked on i_clk; the gated form is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LONGEST_UNIQUE_SYMBOL_RUN_MACROS_SVH
`define LONGEST_UNIQUE_SYMBOL_RUN_MACROS_SVH

// property checked outside reset
`define LUSR_CHK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked in and out of reset
`define LUSR_CHK_RAW(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- design/lusr_pkg.sv -----
// ----------------------------------------------------------------------------
// lusr_pkg
// Types and constants shared by the longest unique symbol run block.
// ----------------------------------------------------------------------------
`default_nettype none

package lusr_pkg;

    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int SYM_VALUES       = 256;
    localparam int RING_AW          = 8;
    localparam int LEN_W            = 9;

    localparam logic [LEN_W-1:0] RUN_MAX = LEN_W'(256);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_DROP,
        ST_DRAIN
    } t_state;

endpackage

`default_nettype wire

// ----- design/lusr_pres_mem.sv -----
// ----------------------------------------------------------------------------
// lusr_pres_mem
// Presence map: one bit per symbol, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lusr_pres_mem #(
    parameter int DEPTH = lusr_pkg::SYMBOL_COUNT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic          i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic               o_rdata
);

    logic r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/lusr_ring_mem.sv -----
// ----------------------------------------------------------------------------
// lusr_ring_mem
// Window ring: symbols in arrival order, registered read with write bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module lusr_ring_mem #(
    parameter int DW = 8,
    parameter int AW = lusr_pkg::RING_AW
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // same-address read returns the data being written
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                o_rdata <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_raddr];
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/longest_unique_symbol_run.sv -----
// ----------------------------------------------------------------------------
// longest_unique_symbol_run
// Sliding repeat-free window over a byte string, one symbol per item.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_stall    i_symbol, i_string_end
//   out      output     o_out_valid / i_out_stall  o_window_len, o_best_len,
//                                                  o_final_flag
//
// An item is looked up in the presence map, then the symbols ahead of its
// repeat are dropped; the ring memory read of the oldest slot sets the drop
// rate of one a cycle. The final item of a string adds a drain over the window
// that clears the presence map. After reset a sweep over all SYMBOL_COUNT
// entries clears the presence map; no item is taken meanwhile. A stalled result
// holds in the output register while the next item is taken; it then waits.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_unique_symbol_run #(
    parameter int SYMBOL_COUNT = lusr_pkg::SYMBOL_COUNT_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [7:0]                 i_symbol,
    input  wire logic                       i_string_end,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [lusr_pkg::LEN_W-1:0]      o_window_len,
    output logic [lusr_pkg::LEN_W-1:0]      o_best_len,
    output logic                            o_final_flag
);

    localparam int SW  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int RAW = lusr_pkg::RING_AW;
    localparam int LW  = lusr_pkg::LEN_W;

    localparam logic [RAW-1:0] PTR_ONE  = RAW'(1);
    localparam logic [LW-1:0]  LEN_ONE  = LW'(1);
    localparam logic [SW-1:0]  CLR_ONE  = SW'(1);
    localparam logic [SW-1:0]  CLR_LAST = SW'(SYMBOL_COUNT - 1);

    lusr_pkg::t_state r_state, n_state;

    logic [SW-1:0]  r_sym, n_sym;
    logic           r_last, n_last;
    logic [RAW-1:0] r_oldest, n_oldest;
    logic [RAW-1:0] r_next, n_next;
    logic [LW-1:0]  r_run, n_run;
    logic [LW-1:0]  r_best, n_best;
    logic [SW-1:0]  r_clr, n_clr;
    logic           r_out_valid, n_out_valid;
    logic [LW-1:0]  r_out_len, n_out_len;
    logic [LW-1:0]  r_out_best, n_out_best;
    logic           r_out_final, n_out_final;

    logic           pres_we, pres_wd, pres_re, pres_q;
    logic [SW-1:0]  pres_wa, pres_ra;
    logic           ring_we, ring_re;
    logic [RAW-1:0] ring_wa, ring_ra;
    logic [SW-1:0]  ring_wd, ring_q;

    logic [SW-1:0]  fold_lut [lusr_pkg::SYM_VALUES];
    logic           out_free, hit, busy_hit, gone_is_sym, do_drop, do_append;
    logic [LW-1:0]  run_app, best_app;
    logic [RAW-1:0] oldest_app;

    for (genvar g = 0; g < lusr_pkg::SYM_VALUES; g++) begin : g_fold
        assign fold_lut[g] = SW'(g % SYMBOL_COUNT);
    end

    lusr_pres_mem #(
        .DEPTH (SYMBOL_COUNT),
        .AW    (SW)
    ) u_pres (
        .i_clk   (i_clk),
        .i_we    (pres_we),
        .i_waddr (pres_wa),
        .i_wdata (pres_wd),
        .i_re    (pres_re),
        .i_raddr (pres_ra),
        .o_rdata (pres_q)
    );

    lusr_ring_mem #(
        .DW (SW),
        .AW (RAW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_wa),
        .i_wdata (ring_wd),
        .i_re    (ring_re),
        .i_raddr (ring_ra),
        .o_rdata (ring_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lusr_pkg::ST_CLEAR;
            r_oldest    <= '0;
            r_next      <= '0;
            r_run       <= '0;
            r_best      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_next      <= n_next;
            r_run       <= n_run;
            r_best      <= n_best;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym       <= n_sym;
        r_last      <= n_last;
        r_out_len   <= n_out_len;
        r_out_best  <= n_out_best;
        r_out_final <= n_out_final;
    end

    always_comb begin
        out_free    = !r_out_valid || !i_out_stall;
        hit         = (r_state == lusr_pkg::ST_LOOK) ? pres_q : 1'b1;
        busy_hit    = hit && (r_run != '0);
        gone_is_sym = (ring_q == r_sym);
        do_drop     = busy_hit && !gone_is_sym;
        do_append   = (!busy_hit || gone_is_sym) && out_free;

        if (busy_hit) begin
            run_app    = r_run;
            oldest_app = r_oldest + PTR_ONE;
        end else begin
            run_app    = (r_run < lusr_pkg::RUN_MAX) ? r_run + LEN_ONE : r_run;
            oldest_app = r_oldest;
        end
        best_app = (run_app > r_best) ? run_app : r_best;
    end

    always_comb begin
        n_state     = r_state;
        n_sym       = r_sym;
        n_last      = r_last;
        n_oldest    = r_oldest;
        n_next      = r_next;
        n_run       = r_run;
        n_best      = r_best;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_len   = r_out_len;
        n_out_best  = r_out_best;
        n_out_final = r_out_final;

        pres_we = 1'b0;
        pres_wa = r_sym;
        pres_wd = 1'b0;
        pres_re = 1'b0;
        pres_ra = fold_lut[i_symbol];
        ring_we = 1'b0;
        ring_wa = r_next;
        ring_wd = r_sym;
        ring_re = 1'b0;
        ring_ra = r_oldest;

        case (r_state)
            lusr_pkg::ST_CLEAR: begin
                pres_we = 1'b1;
                pres_wa = r_clr;
                n_clr   = r_clr + CLR_ONE;
                if (r_clr == CLR_LAST) begin
                    n_state = lusr_pkg::ST_IDLE;
                end
            end
            lusr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_sym   = fold_lut[i_symbol];
                    n_last  = i_string_end;
                    pres_re = 1'b1;
                    ring_re = 1'b1;
                    n_state = lusr_pkg::ST_LOOK;
                end
            end
            lusr_pkg::ST_LOOK, lusr_pkg::ST_DROP: begin
                if (do_drop) begin
                    pres_we  = 1'b1;
                    pres_wa  = ring_q;
                    n_oldest = r_oldest + PTR_ONE;
                    n_run    = r_run - LEN_ONE;
                    ring_re  = 1'b1;
                    ring_ra  = r_oldest + PTR_ONE;
                    n_state  = lusr_pkg::ST_DROP;
                end else if (do_append) begin
                    pres_we     = 1'b1;
                    pres_wd     = 1'b1;
                    ring_we     = 1'b1;
                    n_next      = r_next + PTR_ONE;
                    n_oldest    = oldest_app;
                    n_run       = run_app;
                    n_best      = best_app;
                    n_out_valid = 1'b1;
                    n_out_len   = run_app;
                    n_out_best  = best_app;
                    n_out_final = r_last;
                    if (r_last) begin
                        ring_re = 1'b1;
                        ring_ra = oldest_app;
                        n_state = lusr_pkg::ST_DRAIN;
                    end else begin
                        n_state = lusr_pkg::ST_IDLE;
                    end
                end
            end
            lusr_pkg::ST_DRAIN: begin
                pres_we = 1'b1;
                pres_wa = ring_q;
                if (r_run == LEN_ONE) begin
                    n_oldest = '0;
                    n_next   = '0;
                    n_run    = '0;
                    n_best   = '0;
                    n_state  = lusr_pkg::ST_IDLE;
                end else begin
                    n_oldest = r_oldest + PTR_ONE;
                    n_run    = r_run - LEN_ONE;
                    ring_re  = 1'b1;
                    ring_ra  = r_oldest + PTR_ONE;
                end
            end
            default: begin
                n_state = lusr_pkg::ST_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    assign o_in_stall   = (r_state != lusr_pkg::ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_window_len = r_out_len;
    assign o_best_len   = r_out_best;
    assign o_final_flag = r_out_final;

endmodule

`default_nettype wire

// ----- design/lusr_checker.sv -----
// ----------------------------------------------------------------------------
// lusr_checker
// Port-level checks on the longest unique symbol run block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "longest_unique_symbol_run_macros.svh"

module lusr_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_stall,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic [lusr_pkg::LEN_W-1:0] o_window_len,
    input wire logic [lusr_pkg::LEN_W-1:0] o_best_len,
    input wire logic                       o_final_flag
);

    `LUSR_CHK(a_len_order, o_out_valid |-> (o_window_len != 0) && (o_window_len <= o_best_len) && (o_best_len <= lusr_pkg::RUN_MAX), "window or best length out of order")

    `LUSR_CHK(a_busy_after_take, (i_in_valid && !o_in_stall) |=> o_in_stall, "item taken while previous item still in work")

    `LUSR_CHK(a_out_hold, (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_window_len) && $stable(o_best_len) && $stable(o_final_flag), "stalled result changed")

    `LUSR_CHK_RAW(a_reset_quiet, !i_rst_n |=> !o_out_valid && o_in_stall, "block not quiet after reset")

endmodule

bind longest_unique_symbol_run lusr_checker u_lusr_checker (.*);

`default_nettype wire
